/* rtl/ms_pkg.sv */
package ms_pkg;

   // Element width, fixed by the data format
   localparam int VALUE_W = 64;

   // Default capacity of the element store
   localparam int MAX_ITEMS_DEFAULT = 64;

endpackage

/* rtl/ms_req_if.sv */
interface ms_req_if;

   logic                              valid;
   logic                              ready;
   logic signed [ms_pkg::VALUE_W-1:0] value;
   logic                              last_in;

   modport source (output valid, value, last_in, input ready);
   modport sink   (input valid, value, last_in, output ready);

endinterface

/* rtl/ms_rsp_if.sv */
interface ms_rsp_if;

   logic                              valid;
   logic                              ready;
   logic signed [ms_pkg::VALUE_W-1:0] sorted_value;
   logic                              last_out;
   logic                              overflowed;

   modport source (output valid, sorted_value, last_out, overflowed, input ready);
   modport sink   (input valid, sorted_value, last_out, overflowed, output ready);

endinterface

/* rtl/merge_sorter.sv */
// merge_sorter: collects a set of signed 64-bit values and returns it sorted
// in ascending order.
// req_ch carries one value per transfer; last_in marks the final element and
// starts the sort. Up to MAX_ITEMS elements are kept; further elements are
// dropped and every result of that set then carries overflowed.
// rsp_ch returns one transfer per stored element, ascending, with last_out on
// the final one. req_ch.ready is high only while the block collects a set.
// Phases for a set of n elements, with p = ceil(log2 n) merge passes:
//   load:   a new transfer every cycle;
//   sort:   per element per pass, read both run heads, then write
//           the chosen one; each run pair and each pass adds a setup step;
//   output: per element, read it from memory, then hold it until rsp_ch takes it.
// The sort speed is set by the single write port and the registered read
// of the element memory.
// The memory holds two banks that swap roles each pass (ping-pong), so no
// copy-back is needed. When rsp_ch stalls, the pending result holds and the
// sequencer waits. Reset (synchronous) empties the set and clears the
// overflow flag; memory contents need no clearing.
module merge_sorter #(
   parameter int MAX_ITEMS = ms_pkg::MAX_ITEMS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   ms_req_if.sink   req_ch,
   ms_rsp_if.source rsp_ch
);

   localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int ADDR_W    = IDX_W + 1;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   // run positions may run past n before clamping
   localparam int PW        = CNT_W + 2;
   localparam int VW        = ms_pkg::VALUE_W;

   typedef enum logic [2:0] {
      S_LOAD,
      S_PASS,
      S_MSTART,
      S_RD,
      S_WR,
      S_ORD,
      S_OVAL
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic               src_ff, src_in;
   logic [PW-1:0]      width_ff, width_in;
   logic [PW-1:0]      lo_ff, lo_in;
   logic [PW-1:0]      mid_ff, mid_in;
   logic [PW-1:0]      hi_ff, hi_in;
   logic [PW-1:0]      i_ff, i_in;
   logic [PW-1:0]      j_ff, j_in;
   logic [PW-1:0]      k_ff, k_in;
   logic [CNT_W-1:0]   oi_ff, oi_in;

   // element memory: bank 0 and bank 1, selected by the top address bit
   logic signed [VW-1:0] mem_ff [MEM_DEPTH];
   logic signed [VW-1:0] rd_a_ff, rd_b_ff;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic signed [VW-1:0] wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_a_addr, rd_b_addr;

   logic                 req_xfer, rsp_xfer;
   logic                 store_ok;
   logic [CNT_W-1:0]     count_next;
   logic [PW-1:0]        n_pos;
   logic [PW-1:0]        run_mid, run_hi, lo_step;
   logic                 take_left;
   logic                 out_last;

   assign req_ch.ready = (state_ff == S_LOAD);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (state_ff == S_OVAL);
   assign rsp_xfer     = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.sorted_value = rd_a_ff;
   assign rsp_ch.last_out     = out_last;
   assign rsp_ch.overflowed   = ovf_ff;

   assign store_ok   = (count_ff < CNT_W'(MAX_ITEMS));
   assign count_next = store_ok ? CNT_W'(count_ff + CNT_W'(1)) : count_ff;
   assign n_pos      = PW'(n_ff);
   assign out_last   = (CNT_W'(oi_ff + CNT_W'(1)) == n_ff);

   // run bounds of the next pair, clamped to the set size
   assign lo_step = PW'(lo_ff + PW'(width_ff << 1));
   assign run_mid = (PW'(lo_ff + width_ff) > n_pos) ? n_pos : PW'(lo_ff + width_ff);
   assign run_hi  = (lo_step > n_pos) ? n_pos : lo_step;

   // left head goes first when strictly less or when the right run is exhausted; right wins ties
   assign take_left = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (rd_a_ff < rd_b_ff));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      n_in      = n_ff;
      src_in    = src_ff;
      width_in  = width_ff;
      lo_in     = lo_ff;
      mid_in    = mid_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      oi_in     = oi_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = req_ch.value;
      rd_en     = 1'b0;
      rd_a_addr = '0;
      rd_b_addr = '0;

      case (state_ff)
         S_LOAD: begin
            if (req_xfer) begin
               // store while room is left, else drop and flag
               if (store_ok) begin
                  wr_en   = 1'b1;
                  wr_addr = {1'b0, count_ff[IDX_W-1:0]};
               end else begin
                  ovf_in = 1'b1;
               end
               count_in = count_next;
               if (req_ch.last_in) begin
                  n_in     = count_next;
                  width_in = PW'(1);
                  src_in   = 1'b0;
                  state_in = S_PASS;
               end
            end
         end

         S_PASS: begin
            if (width_ff >= n_pos) begin
               oi_in    = '0;
               state_in = S_ORD;
            end else begin
               lo_in    = '0;
               state_in = S_MSTART;
            end
         end

         S_MSTART: begin
            if (lo_ff >= n_pos) begin
               // pass complete: swap banks and double the run width
               src_in   = ~src_ff;
               width_in = PW'(width_ff << 1);
               state_in = S_PASS;
            end else begin
               mid_in   = run_mid;
               hi_in    = run_hi;
               i_in     = lo_ff;
               j_in     = run_mid;
               k_in     = lo_ff;
               state_in = S_RD;
            end
         end

         S_RD: begin
            // fetch both run heads; an exhausted head reads don't-care data
            rd_en     = 1'b1;
            rd_a_addr = {src_ff, i_ff[IDX_W-1:0]};
            rd_b_addr = {src_ff, j_ff[IDX_W-1:0]};
            state_in  = S_WR;
         end

         S_WR: begin
            wr_en   = 1'b1;
            wr_addr = {~src_ff, k_ff[IDX_W-1:0]};
            wr_data = take_left ? rd_a_ff : rd_b_ff;
            if (take_left) begin
               i_in = PW'(i_ff + PW'(1));
            end else begin
               j_in = PW'(j_ff + PW'(1));
            end
            k_in = PW'(k_ff + PW'(1));
            if (PW'(k_ff + PW'(1)) == hi_ff) begin
               lo_in    = lo_step;
               state_in = S_MSTART;
            end else begin
               state_in = S_RD;
            end
         end

         S_ORD: begin
            rd_en     = 1'b1;
            rd_a_addr = {src_ff, oi_ff[IDX_W-1:0]};
            state_in  = S_OVAL;
         end

         S_OVAL: begin
            // hold the result until the transfer completes
            if (rsp_xfer) begin
               if (out_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  oi_in    = CNT_W'(oi_ff + CNT_W'(1));
                  state_in = S_ORD;
               end
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         n_ff     <= '0;
         src_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         n_ff     <= n_in;
         src_ff   <= src_in;
      end
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      oi_ff    <= oi_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

`ifndef SYNTHESIS
   a_no_load_during_output: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input accepted while a result is pending");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("element count beyond capacity");

   a_merge_write_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> (k_ff < hi_ff) && (k_ff >= lo_ff))
      else $error("merge write outside its run");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_ch.last_out) |=> (count_ff == '0) && !ovf_ff)
      else $error("set not cleared after final result");
`endif

endmodule
